### design/cid_pkg.sv
// Package for the cubic fractional delay line: configuration register
// indexes, field widths and reset constants. No dependencies.
`timescale 1ns / 1ps
package cid_pkg;
	localparam int DLY_SEC_BITS  = 24;
	localparam int DT_FRAC_BITS  = 20;
	localparam int SR_BITS       = 18;
	localparam int BL_BITS       = 13;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 18;

	localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_RATE  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK_LENGTH = 2'd1;

	localparam logic [SR_BITS-1:0]      SR_RESET = 18'd48000;
	localparam logic [BL_BITS-1:0]      BL_RESET = 13'd64;
	localparam logic [DLY_SEC_BITS-1:0] DT_ONE   = 24'h100000;
endpackage

### design/cid_if.sv
// Valid/ready channel interfaces for the cubic fractional delay line.
// Depends on cid_pkg for the delay time width.
`timescale 1ns / 1ps
interface cid_in_if import cid_pkg::*; #(parameter int SAMPLE_BITS = 24);
	logic                    valid;
	logic                    ready;
	logic [SAMPLE_BITS-1:0]  sample;
	logic [DLY_SEC_BITS-1:0] dly_sec;
	logic                    block_start;
	modport source (output valid, sample, dly_sec, block_start, input ready);
	modport sink (input valid, sample, dly_sec, block_start, output ready);
endinterface

interface cid_out_if #(parameter int SAMPLE_BITS = 24);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] delayed_sample;
	modport source (output valid, delayed_sample, input ready);
	modport sink (input valid, delayed_sample, output ready);
endinterface

### design/cubic_interp_fractional_delay.sv
// Fractional delay line with 4-point cubic interpolation over one
// single-port synchronous sample memory. Depends on cid_pkg and cid_if.
//
// Channel  Kind       Payload
// feed     sink       sample, dly_sec, block_start
// result   source     delayed_sample
// cfg      write      cfg_we, cfg_idx, cfg_data (fs_hz, block_length)
//
// An item passes the states in order; a block_start that latches or changes
// the delay adds S_CONV, and the start of a ramp adds the bit-serial slope
// divider S_DIV. The four neighbor reads share the one memory read port.
// Reset leaves the memory untouched; entries not yet written read as zero.
// The result register holds a finished sample until it is taken.
`timescale 1ns / 1ps
module cubic_interp_fractional_delay import cid_pkg::*; #(
	parameter int ADDR_BITS   = 19,
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS   = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	cid_in_if.sink                   feed,
	cid_out_if.source                result
);
	localparam int PA        = ADDR_BITS + FRAC_BITS;
	localparam int DW        = PA + 1;
	localparam int PROD_BITS = DLY_SEC_BITS + SR_BITS;
	localparam int SH_L      = (FRAC_BITS >= DT_FRAC_BITS) ? FRAC_BITS - DT_FRAC_BITS : 0;
	localparam int SH_R      = (FRAC_BITS < DT_FRAC_BITS) ? DT_FRAC_BITS - FRAC_BITS : 0;
	localparam int XW        = PROD_BITS + SH_L;
	localparam int KW        = ((XW > DW) ? XW : DW) + 1;
	localparam int EW        = SAMPLE_BITS + 8;
	localparam int MW        = EW + FRAC_BITS + 1;
	localparam int DCW       = $clog2(DW + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_CONV, S_DIV, S_STEP, S_ADDR, S_RD, S_MC, S_MB, S_MA, S_OUT
	} state_t;

	state_t                        state_q;
	logic [SR_BITS-1:0]            fs_hz_q;
	logic [BL_BITS-1:0]            block_length_q;
	logic [SAMPLE_BITS-1:0]        sample_q;
	logic [DLY_SEC_BITS-1:0]       dt_q;
	logic [PROD_BITS-1:0]          prod_q;
	logic [DW-1:0]                 cur_q;
	logic signed [DW:0]            slope_q;
	logic [BL_BITS-1:0]            ramp_rem_q;
	logic                          started_q;
	logic [DLY_SEC_BITS-1:0]       prev_dt_q;
	logic [DW-1:0]                 dvd_q;
	logic [DW-1:0]                 quo_q;
	logic [BL_BITS-1:0]            rem_q;
	logic [DCW-1:0]                dcnt_q;
	logic                          neg_q;
	logic [ADDR_BITS-1:0]          wp_q;
	logic                          wrapped_q;
	logic [ADDR_BITS-1:0]          ip_q;
	logic [FRAC_BITS-1:0]          fr_q;
	logic [2:0]                    rcnt_q;
	logic                          rd_pend_s1;
	logic [1:0]                    rd_idx_s1;
	logic                          rd_ok_s1;
	logic [SAMPLE_BITS-1:0]        rd_data_s1;
	logic signed [SAMPLE_BITS-1:0] tap_q [4];
	logic signed [MW-1:0]          prodc_q;
	logic signed [MW-1:0]          prodb_q;
	logic signed [MW-1:0]          proda_q;
	logic                          out_v_q;
	logic [SAMPLE_BITS-1:0]        out_d_q;
	logic [SAMPLE_BITS-1:0]        mem [1 << ADDR_BITS];

	logic [BL_BITS-1:0]   len;
	logic [XW-1:0]        dx;
	logic [KW-1:0]        dk, lok, hik;
	logic [DW-1:0]        lo, hi, target;
	logic signed [DW:0]   diff;
	logic [DW-1:0]        absd;
	logic [BL_BITS:0]     rem_sh;
	logic                 ge;
	logic [DW-1:0]        quo_next;
	logic signed [DW+1:0] step_sum;
	logic [DW-1:0]        step_cl;
	logic [PA-1:0]        pos;
	logic                 rd_en;
	logic [ADDR_BITS-1:0] rd_addr;
	logic                 wr_en;
	logic signed [EW-1:0] m1, x0, p1, p2, c_v, b_v, a_v, y_v, smax, smin;
	logic signed [MW-1:0] frs;

	assign len = (block_length_q == '0) ? BL_BITS'(1) : block_length_q;
	assign dx  = (XW'(prod_q) << SH_L) >> SH_R;
	assign lo  = DW'(1) << FRAC_BITS;
	assign hi  = DW'(1) << PA;
	assign dk  = KW'(dx);
	assign lok = KW'(lo);
	assign hik = KW'(hi);

	always_comb begin
		if (dk < lok) begin
			target = lo;
		end else if (dk > hik) begin
			target = hi;
		end else begin
			target = DW'(dk);
		end
	end

	assign diff     = $signed({1'b0, target}) - $signed({1'b0, cur_q});
	assign absd     = diff[DW] ? DW'(-diff) : DW'(diff);
	assign rem_sh   = {rem_q, dvd_q[DW-1]};
	assign ge       = rem_sh >= {1'b0, len};
	assign quo_next = {quo_q[DW-2:0], ge};
	assign step_sum = $signed({2'b00, cur_q}) + (DW+2)'(slope_q);

	always_comb begin
		if (step_sum < $signed({2'b00, lo})) begin
			step_cl = lo;
		end else if (step_sum > $signed({2'b00, hi})) begin
			step_cl = hi;
		end else begin
			step_cl = DW'(step_sum);
		end
	end

	assign pos     = {wp_q, {FRAC_BITS{1'b0}}} - cur_q[PA-1:0];
	assign rd_en   = (state_q == S_RD) && !rcnt_q[2];
	assign rd_addr = ip_q + ADDR_BITS'(rcnt_q[1:0]) - ADDR_BITS'(1);
	assign wr_en   = (state_q == S_OUT) && (!out_v_q || result.ready);

	assign m1   = EW'(tap_q[0]);
	assign x0   = EW'(tap_q[1]);
	assign p1   = EW'(tap_q[2]);
	assign p2   = EW'(tap_q[3]);
	assign frs  = MW'($signed({1'b0, fr_q}));
	assign c_v  = ((x0 - p1) <<< 1) + (x0 - p1) - m1 + p2;
	assign b_v  = (p1 <<< 2) + (m1 <<< 1) - ((x0 <<< 2) + x0) - p2 + EW'(prodc_q >>> FRAC_BITS);
	assign a_v  = p1 - m1 + EW'(prodb_q >>> FRAC_BITS);
	assign y_v  = x0 + EW'(proda_q >>> (FRAC_BITS + 1));
	assign smax = EW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	assign smin = -smax - EW'(1);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wp_q] <= sample_q;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			tap_q[rd_idx_s1] <= rd_ok_s1 ? $signed(rd_data_s1) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			fs_hz_q        <= SR_RESET;
			block_length_q <= BL_RESET;
			cur_q          <= '0;
			slope_q        <= '0;
			ramp_rem_q     <= '0;
			started_q      <= 1'b0;
			prev_dt_q      <= DT_ONE;
			wp_q           <= '0;
			wrapped_q      <= 1'b0;
			rcnt_q         <= '0;
			rd_pend_s1     <= 1'b0;
			rd_idx_s1      <= '0;
			rd_ok_s1       <= 1'b0;
			out_v_q        <= 1'b0;
			out_d_q        <= '0;
			sample_q       <= '0;
			dt_q           <= '0;
			prod_q         <= '0;
			dvd_q          <= '0;
			quo_q          <= '0;
			rem_q          <= '0;
			dcnt_q         <= '0;
			neg_q          <= 1'b0;
			ip_q           <= '0;
			fr_q           <= '0;
			prodc_q        <= '0;
			prodb_q        <= '0;
			proda_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_SAMPLE_RATE:  fs_hz_q <= cfg_data[SR_BITS-1:0];
					REG_BLOCK_LENGTH: block_length_q <= cfg_data[BL_BITS-1:0];
					default: ;
				endcase
			end
			rd_pend_s1 <= rd_en;
			rd_idx_s1  <= rcnt_q[1:0];
			rd_ok_s1   <= wrapped_q || (rd_addr < wp_q);
			if (wr_en) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && result.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (feed.valid) begin
						sample_q <= feed.sample;
						dt_q     <= feed.dly_sec;
						prod_q   <= PROD_BITS'(feed.dly_sec) * PROD_BITS'(fs_hz_q);
						if (feed.block_start && (!started_q || feed.dly_sec != prev_dt_q)) begin
							state_q <= S_CONV;
						end else begin
							state_q <= S_STEP;
						end
					end
				end
				S_CONV: begin
					prev_dt_q <= dt_q;
					if (!started_q) begin
						started_q  <= 1'b1;
						cur_q      <= target;
						ramp_rem_q <= '0;
						slope_q    <= '0;
						state_q    <= S_STEP;
					end else begin
						ramp_rem_q <= len;
						dvd_q      <= absd;
						neg_q      <= diff[DW];
						quo_q      <= '0;
						rem_q      <= '0;
						dcnt_q     <= DCW'(DW);
						state_q    <= S_DIV;
					end
				end
				S_DIV: begin
					dvd_q  <= dvd_q << 1;
					rem_q  <= ge ? BL_BITS'(rem_sh - {1'b0, len}) : rem_sh[BL_BITS-1:0];
					quo_q  <= quo_next;
					dcnt_q <= dcnt_q - DCW'(1);
					if (dcnt_q == DCW'(1)) begin
						slope_q <= neg_q ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (ramp_rem_q != '0) begin
						cur_q      <= step_cl;
						ramp_rem_q <= ramp_rem_q - BL_BITS'(1);
					end
					state_q <= S_ADDR;
				end
				S_ADDR: begin
					ip_q    <= pos[PA-1:FRAC_BITS];
					fr_q    <= pos[FRAC_BITS-1:0];
					rcnt_q  <= '0;
					state_q <= S_RD;
				end
				S_RD: begin
					if (rcnt_q[2]) begin
						state_q <= S_MC;
					end else begin
						rcnt_q <= rcnt_q + 3'd1;
					end
				end
				S_MC: begin
					prodc_q <= frs * MW'(c_v);
					state_q <= S_MB;
				end
				S_MB: begin
					prodb_q <= frs * MW'(b_v);
					state_q <= S_MA;
				end
				S_MA: begin
					proda_q <= frs * MW'(a_v);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (wr_en) begin
						if (y_v > smax) begin
							out_d_q <= smax[SAMPLE_BITS-1:0];
						end else if (y_v < smin) begin
							out_d_q <= smin[SAMPLE_BITS-1:0];
						end else begin
							out_d_q <= y_v[SAMPLE_BITS-1:0];
						end
						wp_q <= wp_q + ADDR_BITS'(1);
						if (wp_q == '1) begin
							wrapped_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign feed.ready            = (state_q == S_IDLE);
	assign result.valid          = out_v_q;
	assign result.delayed_sample = out_d_q;
endmodule

### design/cid_checker.sv
// Port-level checks for the cubic fractional delay line, attached to the
// top level by a bind statement. Depends on cubic_interp_fractional_delay.
`timescale 1ns / 1ps
module cid_checker #(parameter int SAMPLE_BITS = 24) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] out_data
);
	logic in_xfer;
	assign in_xfer = in_valid && in_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped before its transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result data changed while stalled");

	a_busy_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("input accepted while an item is in progress");

	a_busy_two: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> ##1 !in_ready)
		else $error("item finished faster than the memory reads allow");
endmodule

bind cubic_interp_fractional_delay cid_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_cid_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (feed.valid),
	.in_ready (feed.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_data (result.delayed_sample)
);

### sim/cid_delay_checker.sv
// Checker for the cubic fractional delay line: predicts each delayed sample from
// observed feed transfers and register writes and compares result transfers.
// Depends on cid_pkg and the channel interfaces in cid_if.
`timescale 1ns / 1ps
module cid_delay_checker import cid_pkg::*; #(
	parameter int ADDR_BITS   = 19,
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS   = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	cid_in_if                        feed,
	cid_out_if                       result,
	output int                       errors,
	output int                       pending,
	output int                       checked,
	output int                       ramps
);
	localparam int DEPTH = 1 << ADDR_BITS;
	localparam longint DELAY_LO = longint'(1) << FRAC_BITS;
	localparam longint DELAY_HI = longint'(DEPTH) << FRAC_BITS;
	localparam longint SMAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
	localparam longint SMIN = -SMAX - 1;

	logic signed [SAMPLE_BITS-1:0] line_mem [DEPTH];
	logic [SAMPLE_BITS-1:0] expected_q [$];
	logic [SR_BITS-1:0] rate;
	logic [BL_BITS-1:0] blen;
	logic [ADDR_BITS-1:0] wr_ptr;
	longint cur_delay;
	longint slope;
	int unsigned ramp_left;
	logic started;
	logic [DLY_SEC_BITS-1:0] prev_time;

	function automatic longint delay_in_samples(input logic [DLY_SEC_BITS-1:0] t);
		longint d;
		d = (longint'(t) * longint'(rate)) >>> (DT_FRAC_BITS - FRAC_BITS);
		if (d < DELAY_LO)
			d = DELAY_LO;
		if (d > DELAY_HI)
			d = DELAY_HI;
		return d;
	endfunction

	function automatic longint cubic_blend(input longint fr, input longint m1,
			input longint x0, input longint p1, input longint p2);
		longint c, b, a;
		c = 3 * (x0 - p1) - m1 + p2;
		b = 4 * p1 + 2 * m1 - 5 * x0 - p2 + ((fr * c) >>> FRAC_BITS);
		a = p1 - m1 + ((fr * b) >>> FRAC_BITS);
		return x0 + ((fr * a) >>> (FRAC_BITS + 1));
	endfunction

	task automatic predict_delayed(input logic [SAMPLE_BITS-1:0] smp,
			input logic [DLY_SEC_BITS-1:0] t, input logic bs);
		longint len, y;
		logic [63:0] pos;
		logic [ADDR_BITS-1:0] ip;
		longint fr;
		if (bs) begin
			if (!started) begin
				started = 1'b1;
				prev_time = t;
				cur_delay = delay_in_samples(t);
				ramp_left = 0;
				slope = 0;
			end else if (t != prev_time) begin
				len = (blen != 0) ? longint'(blen) : 1;
				slope = (delay_in_samples(t) - cur_delay) / len;
				ramp_left = int'(len);
				prev_time = t;
				ramps++;
			end
		end
		if (ramp_left > 0) begin
			cur_delay += slope;
			if (cur_delay < DELAY_LO)
				cur_delay = DELAY_LO;
			if (cur_delay > DELAY_HI)
				cur_delay = DELAY_HI;
			ramp_left--;
		end
		pos = (64'(wr_ptr) << FRAC_BITS) - 64'(cur_delay);
		ip = pos[FRAC_BITS +: ADDR_BITS];
		fr = longint'(pos & ((64'd1 << FRAC_BITS) - 1));
		y = cubic_blend(fr, line_mem[ip - 1'b1], line_mem[ip], line_mem[ip + 1'b1],
			line_mem[ip + 2'd2]);
		if (y > SMAX)
			y = SMAX;
		if (y < SMIN)
			y = SMIN;
		line_mem[wr_ptr] = smp;
		wr_ptr = wr_ptr + 1'b1;
		expected_q.push_back(y[SAMPLE_BITS-1:0]);
	endtask

	task automatic report(input string what, input logic [SAMPLE_BITS-1:0] got,
			input logic [SAMPLE_BITS-1:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got),
			$signed(want), $realtime);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (line_mem[i])
				line_mem[i] = '0;
			expected_q.delete();
			rate = SR_RESET;
			blen = BL_RESET;
			wr_ptr = '0;
			cur_delay = 0;
			slope = 0;
			ramp_left = 0;
			started = 1'b0;
			prev_time = DT_ONE;
			errors = 0;
			checked = 0;
			ramps = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_SAMPLE_RATE)
					rate = cfg_data[SR_BITS-1:0];
				else if (cfg_idx == REG_BLOCK_LENGTH)
					blen = cfg_data[BL_BITS-1:0];
			end
			if (result.valid && result.ready) begin
				if (expected_q.size() == 0) begin
					report("unexpected transfer", result.delayed_sample, '0);
				end else begin
					if (result.delayed_sample !== expected_q[0])
						report("delayed_sample", result.delayed_sample, expected_q[0]);
					void'(expected_q.pop_front());
					checked++;
				end
			end
			if (feed.valid && feed.ready)
				predict_delayed(feed.sample, feed.dly_sec, feed.block_start);
			pending = expected_q.size();
		end
	end
endmodule

### sim/cubic_interp_fractional_delay_tb.sv
// Testbench top for the cubic fractional delay line: drives feed transfers and
// register writes, applies back-pressure and gives the verdict.
// Depends on cid_pkg, cid_if, the block and cid_delay_checker.
`timescale 1ns / 1ps
module cubic_interp_fractional_delay_tb import cid_pkg::*;;
	localparam int ADDR_BITS   = 19;
	localparam int SAMPLE_BITS = 24;
	localparam int FRAC_BITS   = 16;
	localparam int PHASE_ITEMS = 170;
	localparam int SETTLE      = 80;
	localparam int CYCLE_LIMIT = 2000000;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_idx;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	int errors, pending, checked, ramps;
	int send_idle, recv_idle;
	int sent;
	int cycles = 0;

	cid_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) feed_if ();
	cid_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_if ();

	cubic_interp_fractional_delay #(
		.ADDR_BITS(ADDR_BITS), .SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .feed(feed_if.sink), .result(result_if.source)
	);

	cid_delay_checker #(
		.ADDR_BITS(ADDR_BITS), .SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)
	) checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .feed(feed_if), .result(result_if), .errors(errors),
		.pending(pending), .checked(checked), .ramps(ramps)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			result_if.ready <= 1'b0;
		else
			result_if.ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	task automatic push_sample(input logic [SAMPLE_BITS-1:0] smp,
			input logic [DLY_SEC_BITS-1:0] t, input logic bs);
		if ($urandom_range(0, 99) < send_idle) begin
			feed_if.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle)
				@(posedge clk);
		end
		feed_if.valid <= 1'b1;
		feed_if.sample <= smp;
		feed_if.dly_sec <= t;
		feed_if.block_start <= bs;
		@(posedge clk);
		while (!feed_if.ready)
			@(posedge clk);
		sent++;
		if (sent == 283) begin
			send_idle = 67;
			recv_idle = 15;
		end else if (sent == 566) begin
			send_idle = 0;
			recv_idle = 0;
		end
	endtask

	task automatic push_random();
		logic [DLY_SEC_BITS-1:0] t;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 85)
			t = DLY_SEC_BITS'($urandom_range(0, 3000));
		else if (pick < 95)
			t = DLY_SEC_BITS'($urandom_range(0, 8388608));
		else
			t = ($urandom_range(0, 1) != 0) ? 24'd8388608 : 24'd0;
		push_sample(SAMPLE_BITS'($urandom), t, $urandom_range(0, 9) == 0);
	endtask

	task automatic drain();
		feed_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	int rate_set [5] = '{8000, 192000, 44100, 96000, 8000};
	int blen_set [5] = '{1, 4096, 0, 16, 7};

	initial begin
		sent = 0;
		send_idle = 15;
		recv_idle = 67;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		feed_if.valid = 1'b0;
		feed_if.sample = '0;
		feed_if.dly_sec = '0;
		feed_if.block_start = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reads before the first block start use a zero delay.
		push_sample(24'h7FFFFF, 24'd0, 1'b0);
		push_sample(24'h800000, 24'd8388608, 1'b0);
		push_sample(24'h000001, 24'd500, 1'b0);
		// Zero delay time clamps to one sample, then a delay below two samples.
		push_sample(24'hFFFFFF, 24'd0, 1'b1);
		push_sample(24'h7FFFFF, 24'd0, 1'b0);
		push_sample(24'h800000, 24'd30, 1'b1);
		push_sample(24'h7FFFFF, 24'd30, 1'b0);
		push_sample(24'h800000, 24'd30, 1'b1);
		push_sample(24'h7FFFFF, 24'd45, 1'b0);
		// Ramp toward a longer delay, restarted mid-way by another block start.
		push_sample(24'h800000, 24'd70, 1'b1);
		for (int i = 0; i < 6; i++)
			push_sample((i % 2) ? 24'h7FFFFF : 24'h800000, 24'd70, 1'b0);
		push_sample(24'h123456, 24'd5, 1'b1);
		push_sample(24'hABCDEF, 24'd5, 1'b0);
		// Longest delay saturates at the line depth.
		push_sample(24'h555555, 24'd8388608, 1'b1);
		push_sample(24'hAAAAAA, 24'hFFFFFF, 1'b1);
		push_sample(24'h000000, 24'd100, 1'b1);
		drain();
		write_reg(REG_SPARE_A, 18'h3FFFF);
		write_reg(REG_SPARE_B, 18'h15555);

		for (int p = 0; p < 5; p++) begin
			write_reg(REG_SAMPLE_RATE, CFG_DATA_BITS'(rate_set[p]));
			write_reg(REG_BLOCK_LENGTH, CFG_DATA_BITS'(blen_set[p]));
			for (int i = 0; i < PHASE_ITEMS; i++)
				push_random();
			drain();
		end

		$display("Sent %0d samples over five register settings, %0d results checked.",
			sent, checked);
		$display("Delay ramps started: %0d; idling swapped between the two sides.", ramps);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
